// ----- hdl/q2e_pkg.sv -----
// Shared types, constants and tables for the quaternion to Euler angle pipeline.
package q2e_pkg;

  localparam int CordicSteps = 16;
  localparam int AngW        = 40;   // CORDIC angle accumulator, 32 fraction bits
  localparam int VecW        = 48;   // CORDIC vector width
  localparam int TermW       = 36;   // product sums, 28 fraction bits
  localparam int SqW         = 62;   // radicand width
  localparam int RootW       = 31;   // square root width

  // atan(2^-i) with 32 fraction bits, rounded to nearest
  localparam logic [AngW-1:0] AtanTab [CordicSteps] = '{
    40'd3373259426, 40'd1991351318, 40'd1052175346, 40'd534100635,
    40'd268086748,  40'd134174063,  40'd67103403,   40'd33553749,
    40'd16777131,   40'd8388597,    40'd4194303,    40'd2097152,
    40'd1048576,    40'd524288,     40'd262144,     40'd131072
  };
  localparam logic signed [AngW-1:0] PiQ32 = 40'sd13493037705;

  // Limits after rounding to 13 fraction bits
  localparam logic signed [15:0] LimPi   = 16'sd25736;
  localparam logic signed [15:0] LimHalf = 16'sd12868;

  // State of one vectoring CORDIC lane
  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] z;
  } cordic_t;

  // Item carried through the CORDIC pipeline
  typedef struct packed {
    cordic_t h;
    cordic_t p;
    cordic_t r;
    logic    clamped;
  } lanes_t;

  // One CORDIC micro-rotation
  function automatic cordic_t cordic_step(cordic_t s, int i);
    cordic_t o;
    logic signed [VecW-1:0] dx;
    logic signed [VecW-1:0] dy;
    dx = s.x >>> i;
    dy = s.y >>> i;
    if (!s.y[VecW-1]) begin
      o.x = s.x + dy;
      o.y = s.y - dx;
      o.z = s.z + $signed(AtanTab[i]);
    end else begin
      o.x = s.x - dy;
      o.y = s.y + dx;
      o.z = s.z - $signed(AtanTab[i]);
    end
    return o;
  endfunction

  // Quadrant fold ahead of the iterations
  function automatic cordic_t cordic_init(logic signed [VecW-1:0] y,
                                          logic signed [VecW-1:0] x);
    cordic_t o;
    o.x = x;
    o.y = y;
    o.z = '0;
    if (x[VecW-1]) begin
      o.x = -x;
      o.y = -y;
      o.z = y[VecW-1] ? -PiQ32 : PiQ32;
    end
    return o;
  endfunction

  // Round 32 to 13 fraction bits and saturate
  function automatic logic signed [15:0] angle_out(logic signed [AngW-1:0] z,
                                                   logic signed [15:0] lim);
    logic signed [AngW-1:0] r;
    r = (z + (AngW'(1) <<< 18)) >>> 19;
    if (r > AngW'(lim)) return lim;
    if (r < -AngW'(lim)) return -lim;
    return r[15:0];
  endfunction

endpackage

// ----- hdl/q2e_terms.sv -----
// Products, sums, clamp, pipelined square root of the asin cosine and the lane fold.
module q2e_terms (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [15:0]        q_x,
  input  logic signed [15:0]        q_y,
  input  logic signed [15:0]        q_z,
  input  logic signed [15:0]        q_w,
  output logic                      out_valid,
  output q2e_pkg::lanes_t           out_lanes
);
  localparam int TW = q2e_pkg::TermW;
  localparam int RW = q2e_pkg::RootW;
  localparam int NR = RW;   // one root bit per stage

  // stage 1: products
  logic signed [31:0] xy_r, wz_r, xz_r, wy_r, wx_r, yz_r, ww_r, xx_r, yy_r, zz_r;
  logic               v1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
    if (en) begin
      xy_r <= 32'(q_x) * 32'(q_y); wz_r <= 32'(q_w) * 32'(q_z);
      xz_r <= 32'(q_x) * 32'(q_z); wy_r <= 32'(q_w) * 32'(q_y);
      wx_r <= 32'(q_w) * 32'(q_x); yz_r <= 32'(q_y) * 32'(q_z);
      ww_r <= 32'(q_w) * 32'(q_w); xx_r <= 32'(q_x) * 32'(q_x);
      yy_r <= 32'(q_y) * 32'(q_y); zz_r <= 32'(q_z) * 32'(q_z);
    end
  end

  // stage 2: terms and clamp
  logic signed [TW-1:0] t1_r, t2_r, t4_r, t5_r, t3_r;
  logic                 cl_r, v2_r;
  logic signed [TW-1:0] t3_nxt;
  logic signed [TW-1:0] one;
  assign one    = TW'(1) <<< 28;
  assign t3_nxt = -(TW'(xz_r) - TW'(wy_r)) <<< 1;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      t1_r <= (TW'(xy_r) + TW'(wz_r)) <<< 1;
      t4_r <= (TW'(wx_r) + TW'(yz_r)) <<< 1;
      t2_r <= TW'(ww_r) + TW'(xx_r) - TW'(yy_r) - TW'(zz_r);
      t5_r <= TW'(ww_r) - TW'(xx_r) - TW'(yy_r) + TW'(zz_r);
      cl_r <= (t3_nxt > one) || (t3_nxt < -one);
      t3_r <= (t3_nxt > one) ? one : ((t3_nxt < -one) ? -one : t3_nxt);
    end
  end

  // stage 3: radicand, one minus the square of the asin argument (60 fraction bits)
  logic signed [TW-1:0] t1_3_r, t2_3_r, t4_3_r, t5_3_r, t3_3_r;
  logic                 cl3_r, v3_r;
  logic [q2e_pkg::SqW-1:0] rad_r;
  logic signed [31:0] tq;
  assign tq = 32'(t3_r) <<< 2;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      t1_3_r <= t1_r; t2_3_r <= t2_r; t4_3_r <= t4_r; t5_3_r <= t5_r; t3_3_r <= t3_r;
      cl3_r  <= cl_r;
      rad_r  <= (q2e_pkg::SqW'(1) << 60) - q2e_pkg::SqW'($unsigned(64'(tq) * 64'(tq)));
    end
  end

  // square root stages: one result bit per stage, restoring form
  typedef struct packed {
    logic [q2e_pkg::SqW-1:0] rem;
    logic [RW-1:0]           root;
    logic signed [TW-1:0]    t1, t2, t4, t5, t3;
    logic                    cl;
  } sq_t;
  sq_t           sq0;
  sq_t           sq_r [1:NR];
  logic [NR:1]   sv_r;
  always_comb begin
    sq0.rem  = rad_r;
    sq0.root = '0;
    sq0.t1 = t1_3_r; sq0.t2 = t2_3_r; sq0.t4 = t4_3_r;
    sq0.t5 = t5_3_r; sq0.t3 = t3_3_r; sq0.cl = cl3_r;
  end
  for (genvar k = 0; k < NR; k++) begin : g_sqrt
    localparam int B = NR - 1 - k;
    sq_t  src;
    logic src_v;
    sq_t  sq_nxt;
    logic [q2e_pkg::SqW+1:0] trial;
    logic [q2e_pkg::SqW+1:0] rem_w;
    if (k == 0) begin : g_first
      assign src   = sq0;
      assign src_v = v3_r;
    end else begin : g_next
      assign src   = sq_r[k];
      assign src_v = sv_r[k];
    end
    assign rem_w = (q2e_pkg::SqW + 2)'(src.rem);
    assign trial = ((q2e_pkg::SqW + 2)'(src.root) << (B + 1))
                 + ((q2e_pkg::SqW + 2)'(1) << (2 * B));
    always_comb begin
      sq_nxt = src;
      if (rem_w >= trial) begin
        sq_nxt.rem     = q2e_pkg::SqW'(rem_w - trial);
        sq_nxt.root[B] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[k+1] <= 1'b0;
      else if (en) sv_r[k+1] <= src_v;
      if (en) sq_r[k+1] <= sq_nxt;
    end
  end

  // fold each lane into the right half plane
  logic signed [q2e_pkg::VecW-1:0] ry, rx;
  assign ry = q2e_pkg::VecW'(sq_r[NR].t3) <<< 10;
  assign rx = q2e_pkg::VecW'($signed({1'b0, sq_r[NR].root})) <<< 8;
  always_comb begin
    out_lanes.h = q2e_pkg::cordic_init(q2e_pkg::VecW'(sq_r[NR].t1) <<< 8,
                                       q2e_pkg::VecW'(sq_r[NR].t2) <<< 8);
    out_lanes.p = q2e_pkg::cordic_init(q2e_pkg::VecW'(sq_r[NR].t4) <<< 8,
                                       q2e_pkg::VecW'(sq_r[NR].t5) <<< 8);
    out_lanes.r = q2e_pkg::cordic_init(ry, rx);
    out_lanes.clamped = sq_r[NR].cl;
  end
  assign out_valid = sv_r[NR];

endmodule

// ----- hdl/q2e_cordic.sv -----
// Three vectoring CORDIC lanes, one micro-rotation per stage, then rounding.
module q2e_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  q2e_pkg::lanes_t     in_lanes,
  output logic                out_valid,
  output logic signed [15:0]  heading,
  output logic signed [15:0]  pitch,
  output logic signed [14:0]  roll,
  output logic                clamped
);
  localparam int N = q2e_pkg::CordicSteps;

  q2e_pkg::lanes_t st_r [1:N];
  logic [N:1]      v_r;
  logic            zero_h_r [1:N];
  logic            zero_p_r [1:N];

  // rotation stages
  for (genvar i = 0; i < N; i++) begin : g_rot
    q2e_pkg::lanes_t src;
    logic            src_v;
    logic            src_zh;
    logic            src_zp;
    if (i == 0) begin : g_first
      assign src    = in_lanes;
      assign src_v  = in_valid;
      assign src_zh = (in_lanes.h.x == '0) && (in_lanes.h.y == '0);
      assign src_zp = (in_lanes.p.x == '0) && (in_lanes.p.y == '0);
    end else begin : g_next
      assign src    = st_r[i];
      assign src_v  = v_r[i];
      assign src_zh = zero_h_r[i];
      assign src_zp = zero_p_r[i];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else if (en) v_r[i+1] <= src_v;
      if (en) begin
        st_r[i+1].h       <= q2e_pkg::cordic_step(src.h, i);
        st_r[i+1].p       <= q2e_pkg::cordic_step(src.p, i);
        st_r[i+1].r       <= q2e_pkg::cordic_step(src.r, i);
        st_r[i+1].clamped <= src.clamped;
        zero_h_r[i+1]     <= src_zh;
        zero_p_r[i+1]     <= src_zp;
      end
    end
  end

  // rounding and saturation; a zero heading or pitch vector gives angle zero
  logic signed [15:0] r16;
  assign r16 = q2e_pkg::angle_out(st_r[N].r.z, q2e_pkg::LimHalf);
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= v_r[N];
    if (en) begin
      heading <= zero_h_r[N] ? '0 : q2e_pkg::angle_out(st_r[N].h.z, q2e_pkg::LimPi);
      pitch   <= zero_p_r[N] ? '0 : q2e_pkg::angle_out(st_r[N].p.z, q2e_pkg::LimPi);
      roll    <= r16[14:0];
      clamped <= st_r[N].clamped;
    end
  end

endmodule

// ----- hdl/quaternion_to_euler_angles.sv -----
// Top level: quaternion to Euler angle pipeline with output skid buffer.
//
//  channel | ports          | tdata fields (low bit up)
//  input   | in_t*          | q_x[15:0] q_y[31:16] q_z[47:32] q_w[63:48]
//  output  | out_t*         | heading[15:0] pitch[31:16] roll[46:32] clamped[47]
//
// One request per cycle while the skid register is empty. Stages: three
// product and term stages, a 31-stage one-bit-per-stage square root, 16 CORDIC
// stages and the output register. rst_n is synchronous and clears all valid bits.
// The pipeline advances whenever the skid register is empty; a result held
// there freezes every stage and the input, and loses nothing.
module quaternion_to_euler_angles (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // q_x, q_y, q_z, q_w
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // heading, pitch, roll, clamped
);
  logic            en;
  logic            tv_valid;
  q2e_pkg::lanes_t tv_lanes;
  logic            pv;
  logic [47:0]     pdata;
  logic signed [15:0] h, p;
  logic signed [14:0] r;
  logic            c;
  logic            skid_v_r;
  logic [47:0]     skid_d_r;

  // pipeline advances unless the skid buffer is holding
  assign en        = !skid_v_r;
  assign in_tready = en;

  q2e_terms u_terms (
    .clk, .rst_n, .en,
    .in_valid (in_tvalid),
    .q_x (in_tdata[15:0]), .q_y (in_tdata[31:16]),
    .q_z (in_tdata[47:32]), .q_w (in_tdata[63:48]),
    .out_valid (tv_valid), .out_lanes (tv_lanes)
  );

  q2e_cordic u_cordic (
    .clk, .rst_n, .en,
    .in_valid (tv_valid), .in_lanes (tv_lanes),
    .out_valid (pv), .heading (h), .pitch (p), .roll (r), .clamped (c)
  );

  assign pdata = {c, r, p, h};

  // skid: catch the pipeline output when the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) skid_v_r <= 1'b0;
    else if (skid_v_r && out_tready) skid_v_r <= 1'b0;
    else if (!skid_v_r && pv && !out_tready) skid_v_r <= 1'b1;
    if (!skid_v_r) skid_d_r <= pdata;
  end

  assign out_tvalid = skid_v_r | pv;
  assign out_tdata  = skid_v_r ? skid_d_r : pdata;

`ifndef SYNTHESIS
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_tready |=> skid_v_r && $stable(skid_d_r))
    else $error("skid data lost");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !in_tready)
    else $error("input taken while stalled");
  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[46:32]) <= 15'sd12868 &&
                    $signed(out_tdata[46:32]) >= -15'sd12868))
    else $error("roll out of range");
`endif

endmodule

// ----- verif/quaternion_to_euler_angles_tb.sv -----
// Self-checking testbench for the quaternion to Euler angle pipeline.
`timescale 1ns / 1ps

module quaternion_to_euler_angles_tb;

  localparam int  NumRandom   = 550;
  localparam int  SettleCyc   = 120;     // wait after the last expected result
  localparam longint CycLimit = 400000;
  localparam int  HoldStart   = 180;     // request count at which the sink stalls
  localparam int  HoldCycles  = 300;
  localparam int  DrainAt     = 380;     // request count at which the source drains
  localparam int  QuietFrom   = 240;     // request count window with no idling
  localparam int  QuietTo     = 370;

  // Expected angles of one request
  typedef struct {
    logic signed [15:0] heading;
    logic signed [15:0] pitch;
    logic signed [14:0] roll;
    logic               clamped;
  } angles_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;    // q_x, q_y, q_z, q_w
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;   // heading, pitch, roll, clamped

  quaternion_to_euler_angles uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  logic [63:0] quat_q[$];
  angles_t     angles_q[$];
  longint      cycles;
  int          sent;
  int          received;
  int          errors;
  bit          feed_done;

  // Arctangent table and pi, 32 fraction bits
  longint atan_q32 [16];
  longint pi_q32;

  // atan(1/n) with 60 fraction bits by alternating series
  function automatic longint atan_recip(longint n);
    longint p, acc, k, t;
    p = (longint'(1) << 60) / n;
    acc = 0;
    k = 0;
    while (p > 0) begin
      t = p / (2 * k + 1);
      acc += (k & 1) ? -t : t;
      p = p / (n * n);
      k++;
    end
    return acc;
  endfunction

  function automatic longint narrow60(longint v);
    return (v + (longint'(1) << 27)) >>> 28;
  endfunction

  function automatic void fill_tables();
    longint qpi, acc, k, t;
    qpi = 4 * atan_recip(5) - atan_recip(239);
    pi_q32 = narrow60(4 * qpi);
    for (int i = 0; i < 16; i++) begin
      acc = 0;
      k = 0;
      if (i == 0) begin
        acc = qpi;
      end else begin
        while (i * (2 * k + 1) <= 60) begin
          t = (longint'(1) << (60 - i * (2 * k + 1))) / (2 * k + 1);
          acc += (k & 1) ? -t : t;
          k++;
        end
      end
      atan_q32[i] = narrow60(acc);
    end
  endfunction

  // Vectoring CORDIC, result with 32 fraction bits
  function automatic longint vec_atan2(longint y, longint x);
    longint ang, dx, dy;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      ang = (y >= 0) ? pi_q32 : -pi_q32;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x += dy; y -= dx; ang += atan_q32[i];
      end else begin
        x -= dy; y += dx; ang -= atan_q32[i];
      end
    end
    return ang;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Round to 13 fraction bits and saturate to +-lim
  function automatic longint angle_q13(longint a, longint lim);
    longint r;
    r = (a + (longint'(1) << 18)) >>> 19;
    if (r > lim) return lim;
    if (r < -lim) return -lim;
    return r;
  endfunction

  function automatic angles_t quat_to_angles(logic [63:0] q);
    angles_t e;
    longint x, y, z, w, t1, t2, t3, t4, t5, one, tq, c, lpi, lhalf;
    x = longint'($signed(q[15:0]));
    y = longint'($signed(q[31:16]));
    z = longint'($signed(q[47:32]));
    w = longint'($signed(q[63:48]));
    t1 = 2 * (x * y + w * z);
    t2 = w * w + x * x - y * y - z * z;
    t3 = -2 * (x * z - w * y);
    t4 = 2 * (w * x + y * z);
    t5 = w * w - x * x - y * y + z * z;
    one = longint'(1) << 28;
    e.clamped = 1'b0;
    if (t3 > one) begin
      t3 = one; e.clamped = 1'b1;
    end else if (t3 < -one) begin
      t3 = -one; e.clamped = 1'b1;
    end
    tq = t3 * 4;
    c = longint'(root_floor((longint'(1) << 60) - tq * tq));
    lpi = angle_q13(pi_q32, 64'sd1 << 40);
    lhalf = angle_q13(pi_q32 / 2, 64'sd1 << 40);
    e.heading = 16'(angle_q13(vec_atan2(t1 * 256, t2 * 256), lpi));
    e.pitch   = 16'(angle_q13(vec_atan2(t4 * 256, t5 * 256), lpi));
    e.roll    = 15'(angle_q13(vec_atan2(tq * 256, c * 256), lhalf));
    return e;
  endfunction

  function automatic logic [63:0] pack_quat(int x, int y, int z, int w);
    return {16'(w), 16'(z), 16'(y), 16'(x)};
  endfunction

  // Random quaternion, mostly unit-range, some raw patterns, axis combinations and near gimbal lock
  function automatic logic [63:0] rand_quat();
    int a, b, n;
    case ($urandom_range(0, 9))
      6, 7: return {$urandom, $urandom};
      8: begin
        // x ~ z and w ~ y drive the asin argument near and past +1
        a = $urandom_range(0, 16384) - 8192;
        b = $urandom_range(0, 23170) - 11585;
        n = $urandom_range(0, 6) - 3;
        return pack_quat(a, b + n, a - n, b);
      end
      9: return pack_quat(($urandom_range(0, 2) - 1) * 16384,
                          ($urandom_range(0, 2) - 1) * 16384,
                          ($urandom_range(0, 2) - 1) * 16384,
                          ($urandom_range(0, 2) - 1) * 16384);
      default: return pack_quat($urandom_range(0, 32768) - 16384,
                                $urandom_range(0, 32768) - 16384,
                                $urandom_range(0, 32768) - 16384,
                                $urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Reset, stimulus list, end of run
  initial begin
    rst_n = 1'b0;
    feed_done = 1'b0;
    fill_tables();
    // Directed corners: zero, identity, axes, negative denominators, clamps
    quat_q.push_back(pack_quat(0, 0, 0, 0));
    quat_q.push_back(pack_quat(0, 0, 0, 16384));
    quat_q.push_back(pack_quat(0, 0, 0, -16384));
    quat_q.push_back(pack_quat(16384, 0, 0, 0));
    quat_q.push_back(pack_quat(0, 16384, 0, 0));
    quat_q.push_back(pack_quat(0, 0, 16384, 0));
    quat_q.push_back(pack_quat(-16384, 0, 0, 0));
    quat_q.push_back(pack_quat(0, -16384, 0, 0));
    quat_q.push_back(pack_quat(0, 0, -16384, 0));
    quat_q.push_back(pack_quat(0, 11585, 0, 11585));
    quat_q.push_back(pack_quat(0, -11585, 0, 11585));
    quat_q.push_back(pack_quat(11585, 11585, 11585, 11585));
    quat_q.push_back(pack_quat(11585, -11585, -11585, 11585));
    quat_q.push_back(pack_quat(0, 11586, 0, 11586));
    quat_q.push_back(pack_quat(0, 16384, 0, 16384));
    quat_q.push_back(pack_quat(16384, 0, 16384, 0));
    quat_q.push_back(pack_quat(-32768, -32768, -32768, -32768));
    quat_q.push_back(pack_quat(32767, 32767, 32767, 32767));
    quat_q.push_back(pack_quat(32767, -32768, 32767, -32768));
    quat_q.push_back(pack_quat(-32768, 32767, 0, 0));
    quat_q.push_back(pack_quat(1, 0, 0, -1));
    quat_q.push_back(pack_quat(0, 0, -1, -16384));
    quat_q.push_back(pack_quat(8192, 8192, -8192, -8192));
    for (int i = 0; i < NumRandom; i++) quat_q.push_back(rand_quat());
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (quat_q.size() == 0 && !in_tvalid);
    feed_done = 1'b1;
    wait (angles_q.size() == 0);
    repeat (SettleCyc) @(posedge clk);
    if (errors == 0 && angles_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial cycles = 0;

  // Source: random gaps, a quiet window, one drain pause
  bit draining;
  always @(posedge clk) begin
    logic go;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      sent      <= 0;
      draining  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        angles_q.push_back(quat_to_angles(in_tdata));
        sent <= sent + 1;
        if (sent + 1 == DrainAt) draining <= 1'b1;
      end
      if (draining && angles_q.size() == 0 && !(in_tvalid && in_tready)) draining <= 1'b0;
      if (!in_tvalid || in_tready) begin
        go = quat_q.size() != 0 && !draining && !(in_tvalid && in_tready && sent + 1 == DrainAt);
        if (go && !(sent >= QuietFrom && sent < QuietTo) && $urandom_range(0, 99) < 15)
          go = 1'b0;
        in_tvalid <= go;
        if (go) in_tdata <= quat_q.pop_front();
      end
    end
  end

  // Sink: random stalls, one long hold-off, result checks
  int hold_left;
  bit held;
  always @(posedge clk) begin
    angles_t e;
    logic signed [15:0] h, p;
    logic signed [14:0] r;
    logic cl;
    if (!rst_n) begin
      out_tready <= 1'b0;
      received   <= 0;
      errors     <= 0;
      hold_left  <= 0;
      held       <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        received <= received + 1;
        {cl, r, p, h} = out_tdata;
        if (angles_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result %h", out_tdata);
        end else begin
          e = angles_q.pop_front();
          if (h !== e.heading || p !== e.pitch || r !== e.roll || cl !== e.clamped) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch #%0d: exp h=%0d p=%0d r=%0d c=%0b got h=%0d p=%0d r=%0d c=%0b",
                       received, e.heading, e.pitch, e.roll, e.clamped, h, p, r, cl);
          end
        end
      end
      if (!held && sent >= HoldStart) begin
        held <= 1'b1;
        hold_left <= HoldCycles;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= (sent >= QuietFrom && sent < QuietTo) || $urandom_range(0, 99) >= 15;
      end
    end
  end

endmodule

// ----- sim.f -----
hdl/q2e_pkg.sv
hdl/q2e_terms.sv
hdl/q2e_cordic.sv
hdl/quaternion_to_euler_angles.sv
verif/quaternion_to_euler_angles_tb.sv
